/* sv/smpm_pkg.sv */
// Shared types, constants and the pointer decode of the power monitor register block.
// No dependencies; the register file, the top level, the checker and the testbench import it.
package smpm_pkg;

    localparam int unsigned SLOT_COUNT = 10;
    localparam int unsigned SLOT_W     = 4;

    localparam logic [7:0] PTR_LAST_LOW = 8'h07;
    localparam logic [7:0] PTR_MFR_ID   = 8'hFE;
    localparam logic [7:0] PTR_DIE_ID   = 8'hFF;
    localparam logic [SLOT_W-1:0] SLOT_MFR_ID = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_DIE_ID = 4'd9;

    localparam logic [7:0] BYTE_UNSUPPORTED = 8'hFF;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } slot_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [15:0]       data;
    } rf_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } rf_rd_t;

    // Map a bus pointer onto a register file slot.
    function automatic slot_t slot_of(input logic [7:0] ptr);
        slot_t s;
        s.hit = 1'b0;
        s.idx = '0;
        if (ptr <= PTR_LAST_LOW) begin
            s.hit = 1'b1;
            s.idx = {1'b0, ptr[2:0]};
        end else if (ptr == PTR_MFR_ID) begin
            s.hit = 1'b1;
            s.idx = SLOT_MFR_ID;
        end else if (ptr == PTR_DIE_ID) begin
            s.hit = 1'b1;
            s.idx = SLOT_DIE_ID;
        end
        return s;
    endfunction

endpackage

/* sv/smpm_regfile.sv */
// Ten-entry 16-bit register file: synchronous memory with a registered read port.
// Per-entry valid bits make unwritten entries read as zero. Depends on smpm_pkg.
module smpm_regfile
    import smpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rf_wr_t      wr,
    input  rf_rd_t      rd,
    output logic [15:0] rdata
);

    logic [15:0]           mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    logic [15:0]           rd_reg;
    logic                  rvld_reg;

    always_ff @(posedge clk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rvld_reg <= vld_reg[rd.addr];
            end
        end
    end

    // Never-written entries read as zero through their cleared valid bits.
    assign rdata = rvld_reg ? rd_reg : 16'h0000;

endmodule

/* sv/smbus_power_monitor_regs_top.sv */
// Top level of the SMBus power monitor register block.
// Depends on smpm_pkg and smpm_regfile.
//
// Usage:
//   One bus event is a command word on action/pointer/has_word/word. It is
//   taken at a rising edge where start is high and busy is low. A write
//   (action 0) loads the pointer (zero if unsupported and has_word is set),
//   clears the byte select and, with has_word, stores word in the addressed
//   register. A read (action 1) returns one byte of the register named by the
//   current pointer, high byte first. Every command gives exactly one result
//   on read_byte/pointer_valid, marked by a one-cycle done strobe.
// Timing:
//   Accept edge issues the register file access; the next cycle (busy high)
//   selects the byte and updates pointer state; the result shows with done
//   the cycle after. No new command is taken while busy is high.
//   A new command may be taken in the same cycle that done is shown.
// Reset:
//   rst_n clears pointer, byte select, and marks all ten registers as zero.
//   The receiver cannot stall: done lasts one cycle and is not held.
module smbus_power_monitor_regs_top
    import smpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [7:0]  pointer,
    input  logic        has_word,
    input  logic [15:0] word,
    output logic        done,
    output logic [7:0]  read_byte,
    output logic        pointer_valid
);

    state_t      state_reg, state_next;
    logic        action_reg, action_next;
    logic        wvalid_reg, wvalid_next;
    logic [7:0]  ptr_reg, ptr_next;
    logic        low_reg, low_next;
    logic        done_reg, done_next;
    logic [7:0]  byte_reg, byte_next;
    logic        pvalid_reg, pvalid_next;

    logic        acc;
    slot_t       in_slot;
    slot_t       cur_slot;
    rf_wr_t      rf_wr;
    rf_rd_t      rf_rd;
    logic [15:0] rf_rdata;

    assign acc      = start && (state_reg == ST_IDLE);
    assign in_slot  = slot_of(pointer);
    assign cur_slot = slot_of(ptr_reg);

    // Store the word at the accept edge; reads use the pointer held in ptr_reg.
    always_comb
    begin
        rf_wr.en   = acc && (action == ACT_WRITE) && has_word && in_slot.hit;
        rf_wr.addr = in_slot.idx;
        rf_wr.data = word;
        rf_rd.en   = acc && (action == ACT_READ);
        rf_rd.addr = cur_slot.idx;
    end

    smpm_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rf_wr),
        .rd    (rf_rd),
        .rdata (rf_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        wvalid_next = wvalid_reg;
        ptr_next    = ptr_reg;
        low_next    = low_reg;
        done_next   = 1'b0;
        byte_next   = byte_reg;
        pvalid_next = pvalid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc) begin
                    state_next  = ST_EXEC;
                    action_next = action;
                    if (action == ACT_WRITE) begin
                        wvalid_next = in_slot.hit;
                        low_next    = 1'b0;
                        // An unsupported pointer with data drops back to zero.
                        ptr_next    = (has_word && !in_slot.hit) ? 8'h00 : pointer;
                    end
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (action_reg == ACT_READ) begin
                    if (cur_slot.hit) begin
                        byte_next   = low_reg ? rf_rdata[7:0] : rf_rdata[15:8];
                        pvalid_next = 1'b1;
                        low_next    = !low_reg;
                    end else begin
                        byte_next   = BYTE_UNSUPPORTED;
                        pvalid_next = 1'b0;
                        ptr_next    = 8'h00;
                        low_next    = 1'b0;
                    end
                end else begin
                    byte_next   = 8'h00;
                    pvalid_next = wvalid_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= 8'h00;
            low_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            low_reg   <= low_next;
            done_reg  <= done_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk) begin
        action_reg <= action_next;
        wvalid_reg <= wvalid_next;
        byte_reg   <= byte_next;
        pvalid_reg <= pvalid_next;
    end

    assign busy          = (state_reg == ST_EXEC);
    assign done          = done_reg;
    assign read_byte     = byte_reg;
    assign pointer_valid = pvalid_reg;

`ifndef SYNTHESIS
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not enter execution");
    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execution cycle did not produce a result");
    a_done_only_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a command");
    a_invalid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pointer_valid) |-> (read_byte == BYTE_UNSUPPORTED || read_byte == 8'h00))
        else $error("unsupported pointer returned a data byte");
    a_pointer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pointer_valid && read_byte == BYTE_UNSUPPORTED) |-> (ptr_reg == 8'h00 && !low_reg))
        else $error("failed read left pointer state set");
`endif

endmodule

/* sim/smbus_power_monitor_regs_check.sv */
// Checker for the SMBus power monitor register block: watches the command and result ports,
// predicts each reply from a private register image and compares it field by field.
// Depends on smpm_pkg for pointer codes, action codes and the slot count.
module smbus_power_monitor_regs_check
    import smpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        action,
    input  logic [7:0]  pointer,
    input  logic        has_word,
    input  logic [15:0] word,
    input  logic        done,
    input  logic [7:0]  read_byte,
    input  logic        pointer_valid,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] rd_data;
        logic       ptr_ok;
    } bus_reply_t;

    logic [15:0] reg_image [SLOT_COUNT];
    logic [7:0]  cur_ptr;
    logic        low_next;
    bus_reply_t  replies_due [$];
    int          err_total = 0;

    // Slot of an implemented pointer, -1 otherwise.
    function automatic int reg_index(input logic [7:0] p);
        if (p <= PTR_LAST_LOW)
            return int'(p);
        if (p == PTR_MFR_ID)
            return int'(SLOT_MFR_ID);
        if (p == PTR_DIE_ID)
            return int'(SLOT_DIE_ID);
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        err_total++;
    endtask

    // Advance the register image by one command word and give its reply.
    task automatic predict_access(input logic act, input logic [7:0] ptr, input logic hw,
                                  input logic [15:0] w, output bus_reply_t r);
        int          slot;
        logic [15:0] v;
        if (act == ACT_WRITE)
        begin
            slot     = reg_index(ptr);
            cur_ptr  = ptr;
            low_next = 1'b0;
            if (hw)
            begin
                if (slot >= 0)
                    reg_image[slot] = w;
                else
                    cur_ptr = '0;
            end
            r.rd_data = '0;
            r.ptr_ok  = (slot >= 0);
        end
        else
        begin
            slot = reg_index(cur_ptr);
            if (slot >= 0)
            begin
                v         = reg_image[slot];
                r.rd_data = low_next ? v[7:0] : v[15:8];
                r.ptr_ok  = 1'b1;
                low_next  = ~low_next;
            end
            else
            begin
                cur_ptr   = '0;
                low_next  = 1'b0;
                r.rd_data = BYTE_UNSUPPORTED;
                r.ptr_ok  = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bus_reply_t want;
        bus_reply_t fresh;
        if (!rst_n)
        begin
            foreach (reg_image[i])
                reg_image[i] = '0;
            cur_ptr  = '0;
            low_next = 1'b0;
            replies_due.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // Compare first: a result never belongs to the word taken at this edge.
            if (done)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("result with nothing pending", {7'd0, pointer_valid, read_byte},
                                    16'h0);
                else
                begin
                    want = replies_due.pop_front();
                    if (read_byte !== want.rd_data)
                        report_mismatch("read_byte", {8'd0, read_byte}, {8'd0, want.rd_data});
                    if (pointer_valid !== want.ptr_ok)
                        report_mismatch("pointer_valid", {15'd0, pointer_valid},
                                        {15'd0, want.ptr_ok});
                end
            end
            if (start && !busy)
            begin
                predict_access(action, pointer, has_word, word, fresh);
                replies_due.push_back(fresh);
            end
            outstanding <= replies_due.size();
            mismatches  <= err_total;
        end
    end

endmodule

/* sim/smbus_power_monitor_regs_top_test.sv */
// Testbench top for the SMBus power monitor register block: makes the command stimulus,
// runs the block beside the checker and gives the verdict.
// Depends on smpm_pkg, smbus_power_monitor_regs_top and smbus_power_monitor_regs_check.
module smbus_power_monitor_regs_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smpm_pkg::*;

    // Every block input holds a known value from time zero.
    logic        clk;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic        action   = ACT_WRITE;
    logic [7:0]  pointer  = '0;
    logic        has_word = 1'b0;
    logic [15:0] word     = '0;

    logic        busy;
    logic        done;
    logic [7:0]  read_byte;
    logic        pointer_valid;

    int fail_count;
    int pending;
    int cmds_sent = 0;

    smbus_power_monitor_regs_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .pointer       (pointer),
        .has_word      (has_word),
        .word          (word),
        .done          (done),
        .read_byte     (read_byte),
        .pointer_valid (pointer_valid)
    );

    // The checker sees the same ports and keeps its own model of the register file.
    smbus_power_monitor_regs_check CHECK (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .pointer       (pointer),
        .has_word      (has_word),
        .word          (word),
        .done          (done),
        .read_byte     (read_byte),
        .pointer_valid (pointer_valid),
        .mismatches    (fail_count),
        .outstanding   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: the slowest legal run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Present one command word and hold it until the block takes it. Signals are
    // sampled right at the edge, before the block's own updates land, so busy
    // here is the value that decides acceptance. After acceptance, idle now and
    // then so that gaps fall on both busy and free cycles; keep start high
    // otherwise so that back-to-back words never pulse it low.
    task automatic issue(input logic act, input logic [7:0] ptr, input logic hw,
                         input logic [15:0] w);
        int gap;
        action   <= act;
        pointer  <= ptr;
        has_word <= hw;
        word     <= w;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cmds_sent++;
        gap = 0;
        // Hold off idling for a long stretch in the middle of the run.
        if (!(cmds_sent >= 600 && cmds_sent < 1000) && $urandom_range(0, 99) < 8)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One of the ten implemented pointers, chosen at random.
    function automatic logic [7:0] pick_pointer();
        int pick;
        pick = $urandom_range(0, int'(SLOT_COUNT) - 1);
        if (pick <= int'(PTR_LAST_LOW))
            return 8'(pick);
        return (pick == int'(SLOT_MFR_ID)) ? PTR_MFR_ID : PTR_DIE_ID;
    endfunction

    initial
    begin : stimulus
        int          n_reads;
        int          k;
        logic [7:0]  ptr;
        logic        hw;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Reads of the reset image first, then each register
        // class written with extreme words and read back; register zero is read
        // over both bytes and past the wrap of the byte select.
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_WRITE, 8'h00, 1'b1, 16'hFFFF);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_WRITE, PTR_MFR_ID, 1'b1, 16'hA55A);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_WRITE, PTR_DIE_ID, 1'b1, 16'h0001);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_WRITE, PTR_LAST_LOW, 1'b1, 16'h8000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        // Unsupported pointer without a word: pointer kept, so the next read
        // returns the unsupported byte and falls back to pointer zero.
        issue(ACT_WRITE, 8'h08, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        // Unsupported pointer with a word: nothing stored, pointer drops to zero.
        issue(ACT_WRITE, 8'h80, 1'b1, 16'h1234);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        // Write without a word only moves the pointer and clears the byte select.
        issue(ACT_WRITE, 8'h03, 1'b0, 16'hFFFF);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);
        issue(ACT_WRITE, 8'hFD, 1'b1, 16'hFFFF);
        issue(ACT_READ,  8'hFF, 1'b1, 16'hFFFF);
        issue(ACT_WRITE, 8'h00, 1'b0, 16'h0000);
        issue(ACT_READ,  8'h00, 1'b0, 16'h0000);

        // Random part. Most of it is bus-like traffic: a write that sets the
        // pointer, usually to a real register and often with a word, followed by
        // a few reads. The rest is noise with any action and any pointer.
        while (cmds_sent < 1750)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                ptr = ($urandom_range(0, 99) < 80) ? pick_pointer() : 8'($urandom_range(0, 255));
                hw  = ($urandom_range(0, 99) < 70);
                issue(ACT_WRITE, ptr, hw, 16'($urandom_range(0, 65535)));
                n_reads = $urandom_range(0, 4);
                for (k = 0; k < n_reads; k++)
                    issue(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          16'($urandom_range(0, 65535)));
            end
            else
                issue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        end
        start <= 1'b0;

        // Drain: wait for every reply, then let the pipeline settle.
        @(posedge clk);
        for (k = 0; k < 2000 && pending != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
